@@ hw/rtl/ppd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes for the point to polygon distance block.
package ppd_pkg;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned DIFF_W       = 17;
  localparam int unsigned PROD_W       = 34;
  localparam int unsigned CROSS_W      = 36;
  localparam int unsigned SQ_W         = 34;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned RAD_W        = SQ_W + FRAC_W;
  localparam int unsigned ROOT_W       = RAD_W / 2;
  localparam int unsigned DIST_W       = 25;
  localparam int unsigned OUT_W        = 26;
  localparam int unsigned ITER_W       = 6;
  localparam int unsigned MAXV_DEFAULT = 4096;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_QUERY_X = 1'b0;
  localparam logic REG_QUERY_Y = 1'b1;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sign_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_SEL,
    U_SQRT,
    U_DIV,
    U_DONE
  } unit_state_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_EDGE,
    T_CLOSE
  } top_state_e;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
    sign_e             sgn;
  } edge_res_t;

  function automatic logic opposite(sign_e s, sign_e t);
    return ((s == SGN_POS) && (t == SGN_NEG)) || ((s == SGN_NEG) && (t == SGN_POS));
  endfunction

endpackage

@@ hw/rtl/ppd_edge_unit.sv @@
`timescale 1ns / 1ps
// Edge distance unit: shared multiplier, bit-serial square root and divider.
module ppd_edge_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  sx_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  sy_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  ex_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  ey_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  qx_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  qy_i,
  output ppd_pkg::edge_res_t                  res_o
);

  localparam int unsigned DW = ppd_pkg::DIFF_W;
  localparam int unsigned RW = ppd_pkg::ROOT_W;

  ppd_pkg::unit_state_e state_q, state_d;

  logic signed [DW-1:0] dx_q, dy_q, ax_q, ay_q, bx_q, by_q;
  logic [2:0] step_q;
  logic signed [ppd_pkg::CROSS_W-1:0] cr_q;
  logic [ppd_pkg::SQ_W-1:0] a2_q, b2_q, c2_q;
  logic [ppd_pkg::RAD_W-1:0] op_q;
  logic [RW-1:0] root_q, divisor_q, quo_q;
  logic [RW+1:0] rem_q;
  logic [ppd_pkg::ITER_W-1:0] iter_q;
  logic div_mode_q, ovf_q;
  logic [ppd_pkg::DIST_W-1:0] dist_q;

  logic signed [DW-1:0] ma, mb;
  logic signed [ppd_pkg::PROD_W-1:0] prod;
  logic [ppd_pkg::SQ_W-1:0] acr;
  logic [ppd_pkg::SQ_W:0] sum_ac, sum_bc;
  logic [RW+1:0] sq_rem_n, sq_trial;
  logic [RW-1:0] root_n;
  logic sq_ge;
  logic [RW:0] dv_rem_n;
  logic dv_ge;
  logic [RW-1:0] quo_n;
  logic ovf_n;

  function automatic logic signed [DW-1:0] diff(logic signed [ppd_pkg::COORD_W-1:0] a,
                                                logic signed [ppd_pkg::COORD_W-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  // One 17 x 17 signed multiply per cycle; the step picks the operand pair.
  always_comb begin
    unique case (step_q)
      3'd0: begin ma = dx_q; mb = ay_q; end
      3'd1: begin ma = dy_q; mb = ax_q; end
      3'd2: begin ma = ax_q; mb = ax_q; end
      3'd3: begin ma = ay_q; mb = ay_q; end
      3'd4: begin ma = bx_q; mb = bx_q; end
      3'd5: begin ma = by_q; mb = by_q; end
      3'd6: begin ma = dx_q; mb = dx_q; end
      default: begin ma = dy_q; mb = dy_q; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    acr      = cr_q[ppd_pkg::CROSS_W-1] ? ppd_pkg::SQ_W'(-cr_q) : ppd_pkg::SQ_W'(cr_q);
    sum_ac   = {1'b0, a2_q} + {1'b0, c2_q};
    sum_bc   = {1'b0, b2_q} + {1'b0, c2_q};
    sq_rem_n = {rem_q[RW-1:0], op_q[ppd_pkg::RAD_W-1 -: 2]};
    sq_trial = {root_q, 2'b01};
    sq_ge    = sq_rem_n >= sq_trial;
    root_n   = {root_q[RW-2:0], sq_ge};
    dv_rem_n = {rem_q[RW-1:0], op_q[ppd_pkg::RAD_W-1]};
    dv_ge    = dv_rem_n >= {1'b0, divisor_q};
    quo_n    = {quo_q[RW-2:0], dv_ge};
    ovf_n    = ovf_q | quo_q[RW-1];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppd_pkg::U_IDLE: if (req_i) state_d = ppd_pkg::U_MUL;
      ppd_pkg::U_MUL:  if (step_q == 3'd7) state_d = ppd_pkg::U_SEL;
      ppd_pkg::U_SEL:  state_d = ppd_pkg::U_SQRT;
      ppd_pkg::U_SQRT: begin
        if (iter_q == ppd_pkg::ITER_W'(RW - 1)) begin
          state_d = div_mode_q ? ppd_pkg::U_DIV : ppd_pkg::U_DONE;
        end
      end
      ppd_pkg::U_DIV: begin
        if (iter_q == ppd_pkg::ITER_W'(ppd_pkg::RAD_W - 1)) state_d = ppd_pkg::U_DONE;
      end
      // A new request may follow the finished edge directly.
      ppd_pkg::U_DONE: state_d = req_i ? ppd_pkg::U_MUL : ppd_pkg::U_IDLE;
      default: state_d = ppd_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppd_pkg::U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ppd_pkg::U_IDLE, ppd_pkg::U_DONE: begin
        dx_q   <= diff(ex_i, sx_i);
        dy_q   <= diff(ey_i, sy_i);
        ax_q   <= diff(qx_i, sx_i);
        ay_q   <= diff(qy_i, sy_i);
        bx_q   <= diff(qx_i, ex_i);
        by_q   <= diff(qy_i, ey_i);
        step_q <= 3'd0;
      end
      ppd_pkg::U_MUL: begin
        step_q <= step_q + 3'd1;
        unique case (step_q)
          3'd0: cr_q <= ppd_pkg::CROSS_W'(prod);
          3'd1: cr_q <= cr_q - ppd_pkg::CROSS_W'(prod);
          3'd2: a2_q <= prod[ppd_pkg::SQ_W-1:0];
          3'd3: a2_q <= a2_q + prod[ppd_pkg::SQ_W-1:0];
          3'd4: b2_q <= prod[ppd_pkg::SQ_W-1:0];
          3'd5: b2_q <= b2_q + prod[ppd_pkg::SQ_W-1:0];
          3'd6: c2_q <= prod[ppd_pkg::SQ_W-1:0];
          default: c2_q <= c2_q + prod[ppd_pkg::SQ_W-1:0];
        endcase
      end
      ppd_pkg::U_SEL: begin
        rem_q  <= '0;
        root_q <= '0;
        iter_q <= '0;
        // Obtuse angle at an end: the nearer endpoint is the answer.
        priority if ({1'b0, b2_q} >= sum_ac) begin
          op_q <= {a2_q, {ppd_pkg::FRAC_W{1'b0}}};
          div_mode_q <= 1'b0;
        end else if ({1'b0, a2_q} >= sum_bc) begin
          op_q <= {b2_q, {ppd_pkg::FRAC_W{1'b0}}};
          div_mode_q <= 1'b0;
        end else begin
          op_q <= {c2_q, {ppd_pkg::FRAC_W{1'b0}}};
          div_mode_q <= 1'b1;
        end
      end
      ppd_pkg::U_SQRT: begin
        root_q <= root_n;
        if (iter_q == ppd_pkg::ITER_W'(RW - 1)) begin
          iter_q    <= '0;
          divisor_q <= root_n;
          dist_q    <= root_n;
          if (div_mode_q) begin
            op_q  <= {acr, {ppd_pkg::FRAC_W{1'b0}}};
            rem_q <= '0;
            quo_q <= '0;
            ovf_q <= 1'b0;
          end
        end else begin
          rem_q  <= sq_ge ? (sq_rem_n - sq_trial) : sq_rem_n;
          op_q   <= {op_q[ppd_pkg::RAD_W-3:0], 2'b00};
          iter_q <= iter_q + 1'b1;
        end
      end
      ppd_pkg::U_DIV: begin
        rem_q  <= {1'b0, dv_ge ? (dv_rem_n - {1'b0, divisor_q}) : dv_rem_n};
        quo_q  <= quo_n;
        ovf_q  <= ovf_n;
        op_q   <= {op_q[ppd_pkg::RAD_W-2:0], 1'b0};
        iter_q <= iter_q + 1'b1;
        dist_q <= ovf_n ? '1 : quo_n;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.done     = (state_q == ppd_pkg::U_DONE);
    res_o.distance = dist_q;
    priority if (cr_q > 0) res_o.sgn = ppd_pkg::SGN_POS;
    else if (cr_q < 0)     res_o.sgn = ppd_pkg::SGN_NEG;
    else                   res_o.sgn = ppd_pkg::SGN_ZERO;
  end

endmodule

@@ hw/rtl/point_polygon_distance.sv @@
`timescale 1ns / 1ps
// Top level of the point to convex polygon distance block.
//
// The query point is written over the APB port (query_x at address 0, query_y
// at address 4, both signed 16 bit). Polygon vertices are then given in order,
// one per start transfer, the final one with last_vertex_i set; a vertex is
// taken at a clock edge where start is high and busy is low. For each edge the
// block computes the cross sign and the distance from the point to the segment
// on one shared unit: eight multiplies, a 25 step square root and, when the
// perpendicular distance is needed, a 50 step divide. A vertex keeps busy high
// while its edges run; a final vertex that is not the first runs its own edge
// and then the closing one. The first vertex has no edge of its own and,
// unless it is also final, is taken without raising busy. After the final
// vertex the result appears for exactly one cycle with result_valid_o high;
// the receiver cannot stall it, so it must sample it then. inside_res_o is 1
// when no two neighboring edges have strictly opposite cross signs, and
// doubled_distance_o then holds 0; otherwise it holds twice the minimum
// distance with 8 fraction bits. Non-final vertices beyond MAX_VERTICES - 1
// are dropped. The user must write configuration only while idle (unchecked).
module point_polygon_distance #(
  parameter int unsigned MAX_VERTICES = ppd_pkg::MAXV_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ppd_pkg::COORD_W-1:0]  vertex_x_i,
  input  logic signed [ppd_pkg::COORD_W-1:0]  vertex_y_i,
  input  logic                                last_vertex_i,
  output logic                                result_valid_o,
  output logic                                inside_res_o,
  output logic [ppd_pkg::OUT_W-1:0]           doubled_distance_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppd_pkg::APB_AW-1:0]          paddr,
  input  logic [ppd_pkg::APB_DW-1:0]          pwdata,
  output logic [ppd_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW    = ppd_pkg::COORD_W;

  ppd_pkg::top_state_e state_q, state_d;

  logic signed [CW-1:0] qx_q, qy_q;
  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] vx_q, vy_q;
  logic last_q;
  ppd_pkg::sign_e first_sign_q, prev_sign_q;
  logic conflict_q;
  logic [ppd_pkg::DIST_W-1:0] min_q;
  logic [CNT_W-1:0] count_q;
  logic res_valid_q, res_inside_q;
  logic [ppd_pkg::OUT_W-1:0] res_dist_q;

  logic accept, drop;
  logic req;
  logic signed [CW-1:0] sx, sy, ex, ey;
  ppd_pkg::edge_res_t eres;
  logic [ppd_pkg::DIST_W-1:0] min_n;
  logic conflict_close;

  // APB: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == ppd_pkg::REG_QUERY_Y) prdata = ppd_pkg::APB_DW'(qy_q);
    else                                  prdata = ppd_pkg::APB_DW'(qx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ppd_pkg::REG_QUERY_X) qx_q <= pwdata[CW-1:0];
      else                                  qy_q <= pwdata[CW-1:0];
    end
  end

  assign busy   = (state_q != ppd_pkg::T_IDLE);
  assign accept = start && !busy;
  assign drop   = !last_vertex_i &&
                  ((CNT_W + 1)'(count_q) + 1'b1 >= (CNT_W + 1)'(MAX_VERTICES));

  // Launch an edge: the vertex edge at accept, the closing edge after it or, for a lone vertex, at accept.
  always_comb begin
    req = 1'b0;
    sx  = prev_x_q;
    sy  = prev_y_q;
    ex  = vertex_x_i;
    ey  = vertex_y_i;
    if (state_q == ppd_pkg::T_IDLE) begin
      if (accept && !drop) begin
        if (count_q != '0) begin
          req = 1'b1;
        end else if (last_vertex_i) begin
          // A lone vertex only has its zero-length closing edge.
          req = 1'b1;
          sx  = vertex_x_i;
          sy  = vertex_y_i;
        end
      end
    end else if (state_q == ppd_pkg::T_EDGE && eres.done && last_q) begin
      req = 1'b1;
      sx  = vx_q;
      sy  = vy_q;
      ex  = first_x_q;
      ey  = first_y_q;
    end
  end

  ppd_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .sx_i   (sx),
    .sy_i   (sy),
    .ex_i   (ex),
    .ey_i   (ey),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .res_o  (eres)
  );

  assign min_n = (eres.distance < min_q) ? eres.distance : min_q;
  assign conflict_close = conflict_q || ((count_q >= CNT_W'(2)) &&
                          (ppd_pkg::opposite(prev_sign_q, eres.sgn) ||
                           ppd_pkg::opposite(eres.sgn, first_sign_q)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppd_pkg::T_IDLE: begin
        if (accept && !drop) begin
          if (count_q != '0)      state_d = ppd_pkg::T_EDGE;
          else if (last_vertex_i) state_d = ppd_pkg::T_CLOSE;
        end
      end
      ppd_pkg::T_EDGE: begin
        if (eres.done) state_d = last_q ? ppd_pkg::T_CLOSE : ppd_pkg::T_IDLE;
      end
      ppd_pkg::T_CLOSE: if (eres.done) state_d = ppd_pkg::T_IDLE;
      default: state_d = ppd_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ppd_pkg::T_IDLE;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      first_sign_q <= ppd_pkg::SGN_ZERO;
      prev_sign_q  <= ppd_pkg::SGN_ZERO;
      conflict_q   <= 1'b0;
      min_q        <= '1;
      count_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      unique case (state_q)
        ppd_pkg::T_IDLE: begin
          if (accept && !drop && count_q == '0) begin
            first_x_q <= vertex_x_i;
            first_y_q <= vertex_y_i;
            prev_x_q  <= vertex_x_i;
            prev_y_q  <= vertex_y_i;
            count_q   <= CNT_W'(1);
          end
        end
        ppd_pkg::T_EDGE: begin
          if (eres.done) begin
            min_q    <= min_n;
            prev_x_q <= vx_q;
            prev_y_q <= vy_q;
            count_q  <= count_q + 1'b1;
            if (count_q == CNT_W'(1)) first_sign_q <= eres.sgn;
            else if (ppd_pkg::opposite(prev_sign_q, eres.sgn)) conflict_q <= 1'b1;
            prev_sign_q <= eres.sgn;
          end
        end
        ppd_pkg::T_CLOSE: begin
          if (eres.done) begin
            res_valid_q  <= 1'b1;
            first_x_q    <= '0;
            first_y_q    <= '0;
            prev_x_q     <= '0;
            prev_y_q     <= '0;
            first_sign_q <= ppd_pkg::SGN_ZERO;
            prev_sign_q  <= ppd_pkg::SGN_ZERO;
            conflict_q   <= 1'b0;
            min_q        <= '1;
            count_q      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Vertex payload and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q   <= vertex_x_i;
      vy_q   <= vertex_y_i;
      last_q <= last_vertex_i;
    end
    if (state_q == ppd_pkg::T_CLOSE && eres.done) begin
      res_inside_q <= !conflict_close;
      res_dist_q   <= conflict_close ? {min_n, 1'b0} : '0;
    end
  end

  assign result_valid_o     = res_valid_q;
  assign inside_res_o       = res_inside_q;
  assign doubled_distance_o = res_dist_q;

endmodule

@@ tb/point_polygon_distance_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the point to convex polygon distance block.
module point_polygon_distance_test;
  import ppd_pkg::*;

  localparam int unsigned MAXV = MAXV_DEFAULT;
  localparam logic [63:0] DMAX = 64'h1FF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] vertex_x_i = '0;
  logic signed [COORD_W-1:0] vertex_y_i = '0;
  logic last_vertex_i = 1'b0;
  logic result_valid_o;
  logic inside_res_o;
  logic [OUT_W-1:0] doubled_distance_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  point_polygon_distance DUT (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic              in_poly;
    logic [OUT_W-1:0]  dist2;
  } answer_t;

  // Predictor state, a copy of the block's polygon state.
  logic signed [COORD_W-1:0] qx, qy, fx, fy, px, py;
  sign_e first_sgn, prev_sgn;
  logic conflict;
  logic [63:0] min_d;
  int unsigned nverts;

  answer_t answers_due[$];
  int unsigned errors;
  int send_gap_pct;

  // Prints one line for a mismatch and counts it.
  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic is_opposite(sign_e s, sign_e t);
    return (s == SGN_POS && t == SGN_NEG) || (s == SGN_NEG && t == SGN_POS);
  endfunction

  function automatic void clear_poly();
    fx = 0; fy = 0; px = 0; py = 0;
    first_sgn = SGN_ZERO; prev_sgn = SGN_ZERO;
    conflict = 0; min_d = DMAX; nverts = 0;
  endfunction

  // Folds one edge into the running minimum and returns its cross sign.
  function automatic sign_e edge_eval(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, ax, ay, bx, by, cr;
    logic [63:0] a2, b2, c2, d, cw, acr;
    dx = ex - sx; dy = ey - sy;
    ax = longint'(qx) - sx; ay = longint'(qy) - sy;
    bx = longint'(qx) - ex; by = longint'(qy) - ey;
    cr = dx * ay - dy * ax;
    acr = cr < 0 ? -cr : cr;
    a2 = ax * ax + ay * ay;
    b2 = bx * bx + by * by;
    c2 = dx * dx + dy * dy;
    if (b2 >= a2 + c2) d = int_sqrt(a2 << 16);
    else if (a2 >= b2 + c2) d = int_sqrt(b2 << 16);
    else begin
      cw = int_sqrt(c2 << 16);
      d = (cw != 0) ? (acr << 16) / cw : 0;
    end
    if (d > DMAX) d = DMAX;
    if (d < min_d) min_d = d;
    if (cr > 0) return SGN_POS;
    if (cr < 0) return SGN_NEG;
    return SGN_ZERO;
  endfunction

  function automatic void predict_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                         logic last);
    sign_e s;
    answer_t a;
    if (!last && nverts + 1 >= MAXV) return;
    if (nverts == 0) begin
      fx = vx; fy = vy;
    end else begin
      s = edge_eval(px, py, vx, vy);
      if (nverts == 1) first_sgn = s;
      else if (is_opposite(prev_sgn, s)) conflict = 1;
      prev_sgn = s;
    end
    px = vx; py = vy;
    nverts++;
    if (!last) return;
    s = edge_eval(px, py, fx, fy);
    if (nverts >= 2 && (is_opposite(prev_sgn, s) || is_opposite(s, first_sgn)))
      conflict = 1;
    a.in_poly = !conflict;
    a.dist2 = conflict ? OUT_W'(min_d * 2) : '0;
    answers_due.push_back(a);
    clear_poly();
  endfunction

  // Checks every result strobe against the oldest expected answer.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (answers_due.size() == 0) begin
        report("result with no answer expected");
      end else begin
        automatic answer_t a = answers_due.pop_front();
        if (inside_res_o !== a.in_poly)
          report($sformatf("inside %b, expected %b", inside_res_o, a.in_poly));
        if (doubled_distance_o !== a.dist2)
          report($sformatf("distance %0d, expected %0d", doubled_distance_o, a.dist2));
      end
    end
  end

  // Sends one vertex and holds start until the transfer takes place; start
  // stays high afterwards until the next idle cycle, register write or drain.
  task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    vertex_x_i <= vx;
    vertex_y_i <= vy;
    last_vertex_i <= last;
    predict_vertex(vx, vy, last);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Waits for every answer, then lets the unit drain before any register write.
  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    start <= 1'b0;
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'($urandom_range(65535)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_QUERY_X) qx = val; else qy = val;
    @(posedge clk_i);
  endtask

  task automatic set_query(logic [15:0] x, logic [15:0] y);
    drain();
    write_reg(REG_QUERY_X, x);
    write_reg(REG_QUERY_Y, y);
  endtask

  // A regular-ish convex polygon around a center, with random content.
  task automatic send_convex(int n, int r, int cx, int cy);
    real ang;
    for (int i = 0; i < n; i++) begin
      ang = 6.2831853 * i / n;
      send_vertex(16'(cx + $rtoi(r * $cos(ang))), 16'(cy + $rtoi(r * $sin(ang))),
                  i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_query(16'h0000, 16'h0000);
    send_vertex(16'sd5, 16'sd5, 1'b1);                      // single vertex
    send_vertex(16'sd3, 16'sd0, 1'b0); send_vertex(16'sd3, 16'sd0, 1'b1); // zero edge
    send_vertex(-16'sd10, 16'sd4, 1'b0); send_vertex(16'sd10, 16'sd4, 1'b1); // two vertex
    send_vertex(16'sd0, 16'sd0, 1'b0); send_vertex(16'sd9, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd9, 1'b1);                      // point on a vertex
    set_query(16'h7FFF, 16'h7FFF);
    send_vertex(16'h8000, 16'h8000, 1'b0); send_vertex(16'h7FFF, 16'h8000, 1'b0);
    send_vertex(16'h8000, 16'h7FFF, 1'b1);                  // far corner, outside
    set_query(16'h8000, 16'h0000);
    send_vertex(16'h7FFF, 16'h7FFF, 1'b0); send_vertex(16'h7FFF, 16'h8000, 1'b1);
    send_vertex(16'sd100, 16'sd0, 1'b0);
    write_reg(REG_QUERY_Y, 16'sd50);                        // write mid-polygon
    send_vertex(16'sd100, 16'sd100, 1'b0); send_vertex(16'sd0, 16'sd100, 1'b1);
  endtask

  task automatic test_random(int count);
    int sent, n;
    sent = 0;
    while (sent < count) begin
      if (($urandom_range(9)) == 0) begin
        set_query(16'($urandom), 16'($urandom));
      end
      n = $urandom_range(1, 8);
      if ($urandom_range(4) != 0) begin
        send_convex(n, $urandom_range(1, 12000), $urandom_range(0, 20000) - 10000,
                    $urandom_range(0, 20000) - 10000);
      end else begin
        for (int i = 0; i < n; i++) send_vertex(16'($urandom), 16'($urandom), i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    errors = 0;
    send_gap_pct = 9;
    clear_poly();
    qx = 0; qy = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    send_gap_pct = 66;
    test_random(500);
    send_gap_pct = 0;
    test_random(560);
    set_query(16'h8000, 16'h7FFF);
    test_random(40);
    drain();
    if (errors == 0 && answers_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
